[hdl/ptsd_pkg.sv]
// ============================================================================
// ptsd_pkg
// Shared widths, types and codes for the point-to-triangle distance core.
// ============================================================================
`default_nettype none

package ptsd_pkg;

    localparam int COORD_W    = 16;
    localparam int RATIO_FRAC = 16;
    localparam int DOT_W      = 2 * COORD_W + 4;
    localparam int WIDE_W     = 2 * DOT_W + 4;
    localparam int Q_W        = RATIO_FRAC + 1;
    localparam int PRD_W      = DOT_W + Q_W + 1;
    localparam int U_W        = DOT_W + 4;
    localparam int QP_W       = U_W + Q_W + 1;
    localparam int ACC_W      = 48;
    localparam int DIST_W     = 34;
    localparam int REG_W      = 3;
    localparam int DIV_STEPS  = RATIO_FRAC;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam int PIPE_LAT   = 7 + DIV_LAT + 5;

    typedef logic signed [COORD_W:0]     t_ext;
    typedef logic signed [2*COORD_W+1:0] t_p34;
    typedef logic signed [DOT_W-1:0]     t_dot;
    typedef logic signed [WIDE_W-1:0]    t_wide;
    typedef logic        [Q_W-1:0]       t_ratio;
    typedef logic signed [PRD_W-1:0]     t_prd;
    typedef logic signed [U_W-1:0]       t_u;
    typedef logic signed [QP_W-1:0]      t_qp;
    typedef logic signed [ACC_W-1:0]     t_acc;

    localparam t_ratio RATIO_ONE = {1'b1, {RATIO_FRAC{1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [2:0] KIND_C    = 3'd0;
    localparam logic [2:0] KIND_V1   = 3'd1;
    localparam logic [2:0] KIND_V2   = 3'd2;
    localparam logic [2:0] KIND_LIN  = 3'd3;
    localparam logic [2:0] KIND_QUAD = 3'd4;

    localparam logic [1:0] QSEL_INT = 2'd0;
    localparam logic [1:0] QSEL_S   = 2'd1;
    localparam logic [1:0] QSEL_T   = 2'd2;

    localparam logic [REG_W-1:0] REG_INT = 3'd0;
    localparam logic [REG_W-1:0] REG_E12 = 3'd1;
    localparam logic [REG_W-1:0] REG_V2  = 3'd2;
    localparam logic [REG_W-1:0] REG_E02 = 3'd3;
    localparam logic [REG_W-1:0] REG_V0  = 3'd4;
    localparam logic [REG_W-1:0] REG_E01 = 3'd5;
    localparam logic [REG_W-1:0] REG_V1  = 3'd6;

    typedef struct packed {
        t_dot a00;
        t_dot a01;
        t_dot a11;
        t_dot b0;
        t_dot b1;
        t_dot c;
    } t_dots;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] qsel;
        t_dot       lin_b;
        t_wide      a_num;
        t_wide      a_den;
    } t_sel;

    typedef struct packed {
        logic [2:0]       kind;
        logic [1:0]       qsel;
        t_dot             lin_b;
        t_dots            d;
        logic [REG_W-1:0] region;
        logic             degen;
    } t_ctx;

endpackage

`default_nettype wire

[hdl/ptsd_div.sv]
// ============================================================================
// ptsd_div
// Pipelined restoring divider: floor(num * 2^RATIO_FRAC / den), held to 0..1.
// ============================================================================
`default_nettype none

module ptsd_div (
    input  wire logic            i_clk,
    input  wire ptsd_pkg::t_wide i_num,
    input  wire ptsd_pkg::t_wide i_den,
    output ptsd_pkg::t_ratio     o_q
);
    import ptsd_pkg::*;

    localparam int REM_W = WIDE_W - 1;

    logic [REM_W-1:0]      r_rem  [DIV_STEPS+1];
    logic [REM_W-1:0]      r_den  [DIV_STEPS+1];
    logic [RATIO_FRAC-1:0] r_q    [DIV_STEPS+1];
    logic                  r_zero [DIV_STEPS+1];
    logic                  r_one  [DIV_STEPS+1];

    logic [REM_W:0]   n_sh  [DIV_STEPS];
    logic [REM_W:0]   n_sub [DIV_STEPS];
    logic             n_ge  [DIV_STEPS];
    logic             n_zero;
    logic             n_one;

    always_comb begin
        n_zero = (i_num <= 0) || (i_den <= 0);
        n_one  = !n_zero && (i_num >= i_den);
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_sh[k]  = {r_rem[k], 1'b0};
            n_sub[k] = n_sh[k] - {1'b0, r_den[k]};
            n_ge[k]  = n_sh[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num[REM_W-1:0];
        r_den[0]  <= i_den[REM_W-1:0];
        r_q[0]    <= '0;
        r_zero[0] <= n_zero;
        r_one[0]  <= n_one;
        for (int k = 0; k < DIV_STEPS; k++) begin
            r_rem[k+1]  <= n_ge[k] ? n_sub[k][REM_W-1:0] : n_sh[k][REM_W-1:0];
            r_den[k+1]  <= r_den[k];
            r_q[k+1]    <= {r_q[k][RATIO_FRAC-2:0], n_ge[k]};
            r_zero[k+1] <= r_zero[k];
            r_one[k+1]  <= r_one[k];
        end
    end

    assign o_q = r_one[DIV_STEPS]  ? RATIO_ONE :
                 r_zero[DIV_STEPS] ? '0 : {1'b0, r_q[DIV_STEPS]};

endmodule

`default_nettype wire

[hdl/point_triangle_sq_distance_core.sv]
// ============================================================================
// point_triangle_sq_distance_core
// Squared distance from a query point to a 3-D triangle, fully pipelined.
// ============================================================================
//  channel   handshake          payload
//  input     start / busy       i_vertex{0,1,2}_{x,y,z}, i_query_{x,y,z}
//  result    o_valid (strobe)   o_sq_distance, o_region, o_degenerate
//
//  One item per cycle while busy is low; results leave in the order items are taken.
//  Two 16-step ratio dividers sit between classify and eval.
//  busy is high only during reset and the first cycle after it.
//  Results cannot be held off; the pipeline never stalls.
//  Reset clears the valid chain and sets busy; no other register is reset.
// ============================================================================
`default_nettype none

module point_triangle_sq_distance_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex0_x,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex0_y,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex0_z,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex1_x,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex1_y,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex1_z,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex2_x,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex2_y,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_vertex2_z,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_query_x,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_query_y,
    input  wire logic signed [ptsd_pkg::COORD_W-1:0] i_query_z,
    output logic                                     o_valid,
    output logic [ptsd_pkg::DIST_W-1:0]              o_sq_distance,
    output logic [ptsd_pkg::REG_W-1:0]               o_region,
    output logic                                     o_degenerate
);
    import ptsd_pkg::*;

    // control
    logic                r_busy;
    logic [PIPE_LAT-1:0] r_vld;
    logic                n_acc;

    // stage 1..3: edges, products, dots
    t_ext  n_diff [3];
    t_ext  n_e0   [3];
    t_ext  n_e1   [3];
    t_ext  r_s1_diff [3];
    t_ext  r_s1_e0   [3];
    t_ext  r_s1_e1   [3];
    t_p34  r_s2_p [6][3];
    t_dots r_s3_d;

    // stage 4..6: wide products, det/s/t, flags
    t_dots r_s4_d;
    t_wide r_s4_m [6];
    t_dots r_s5_d;
    t_wide r_s5_det;
    t_wide r_s5_s;
    t_wide r_s5_t;
    t_wide n_det_raw;
    t_dots r_s6_d;
    t_wide r_s6_det;
    t_wide r_s6_s;
    t_wide r_s6_t;
    logic  r_s6_dz;
    logic  r_s6_st_le;
    logic  r_s6_b0_neg;
    logic  r_s6_b1_neg;
    logic  r_s6_b0_far;
    logic  r_s6_b1_far;
    t_wide r_s6_num2;
    t_wide r_s6_num6;
    t_wide r_s6_denom;

    // stage 7: selection
    t_sel             n_sel;
    logic [REG_W-1:0] n_region;
    t_ctx             r_s7_ctx;
    t_wide            r_s7_anum;
    t_wide            r_s7_aden;
    t_wide            r_s7_bnum;
    t_wide            r_s7_bden;

    // divider and context delay
    t_ratio w_qa;
    t_ratio w_qb;
    t_ctx   r_dly [DIV_LAT];

    // evaluation
    t_ratio n_s;
    t_ratio n_t;
    t_ctx   r_q1_ctx;
    t_ratio r_q1_s;
    t_ratio r_q1_t;
    t_prd   r_q1_p [5];

    logic signed [PRD_W:0] n_sum_u;
    logic signed [PRD_W:0] n_sum_v;
    t_ratio           r_q2_s;
    t_ratio           r_q2_t;
    t_u               r_q2_u;
    t_u               r_q2_v;
    t_acc             r_q2_lin;
    t_acc             r_q2_v1;
    t_acc             r_q2_v2;
    t_acc             r_q2_c;
    logic [2:0]       r_q2_kind;
    logic [REG_W-1:0] r_q2_region;
    logic             r_q2_degen;

    t_qp              r_q3_us;
    t_qp              r_q3_vt;
    t_acc             r_q3_lin;
    t_acc             r_q3_v1;
    t_acc             r_q3_v2;
    t_acc             r_q3_c;
    logic [2:0]       r_q3_kind;
    logic [REG_W-1:0] r_q3_region;
    logic             r_q3_degen;

    logic signed [QP_W:0] n_sum_q;
    t_acc             n_dist;
    t_acc             r_q4_dist;
    logic [REG_W-1:0] r_q4_region;
    logic             r_q4_degen;

    logic [DIST_W-1:0] r_out_dist;
    logic [REG_W-1:0]  r_out_region;
    logic              r_out_degen;

    function automatic t_sel f_edge01(t_dots d, logic neg, logic far);
        t_sel r;
        r       = '0;
        r.lin_b = d.b0;
        r.a_num = -t_wide'(d.b0);
        r.a_den = t_wide'(d.a00);
        if (!neg) begin
            r.kind = KIND_C;
        end else if (far) begin
            r.kind = KIND_V1;
        end else begin
            r.kind = KIND_LIN;
        end
        return r;
    endfunction

    function automatic t_sel f_edge02(t_dots d, logic neg, logic far);
        t_sel r;
        r       = '0;
        r.lin_b = d.b1;
        r.a_num = -t_wide'(d.b1);
        r.a_den = t_wide'(d.a11);
        if (!neg) begin
            r.kind = KIND_C;
        end else if (far) begin
            r.kind = KIND_V2;
        end else begin
            r.kind = KIND_LIN;
        end
        return r;
    endfunction

    function automatic t_sel f_edge12(t_wide numer, t_wide denom, logic s_side);
        t_sel r;
        r       = '0;
        r.a_num = numer;
        r.a_den = denom;
        if (numer >= denom) begin
            r.kind = s_side ? KIND_V1 : KIND_V2;
        end else begin
            r.kind = KIND_QUAD;
            r.qsel = s_side ? QSEL_S : QSEL_T;
        end
        return r;
    endfunction

    assign n_acc = start && !busy;
    assign busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_LAT-2:0], n_acc};
        end
    end

    // stage 1
    always_comb begin
        n_diff[0] = t_ext'(i_vertex0_x) - t_ext'(i_query_x);
        n_diff[1] = t_ext'(i_vertex0_y) - t_ext'(i_query_y);
        n_diff[2] = t_ext'(i_vertex0_z) - t_ext'(i_query_z);
        n_e0[0]   = t_ext'(i_vertex1_x) - t_ext'(i_vertex0_x);
        n_e0[1]   = t_ext'(i_vertex1_y) - t_ext'(i_vertex0_y);
        n_e0[2]   = t_ext'(i_vertex1_z) - t_ext'(i_vertex0_z);
        n_e1[0]   = t_ext'(i_vertex2_x) - t_ext'(i_vertex0_x);
        n_e1[1]   = t_ext'(i_vertex2_y) - t_ext'(i_vertex0_y);
        n_e1[2]   = t_ext'(i_vertex2_z) - t_ext'(i_vertex0_z);
    end

    always_comb begin
        n_det_raw = r_s4_m[0] - r_s4_m[1];
        n_sel     = '0;
        n_region  = REG_INT;
        if (r_s6_st_le) begin
            if (r_s6_s < 0) begin
                if (r_s6_t < 0) begin
                    n_region = REG_V0;
                    n_sel    = r_s6_b0_neg ? f_edge01(r_s6_d, r_s6_b0_neg, r_s6_b0_far)
                                           : f_edge02(r_s6_d, r_s6_b1_neg, r_s6_b1_far);
                end else begin
                    n_region = REG_E02;
                    n_sel    = f_edge02(r_s6_d, r_s6_b1_neg, r_s6_b1_far);
                end
            end else if (r_s6_t < 0) begin
                n_region = REG_E01;
                n_sel    = f_edge01(r_s6_d, r_s6_b0_neg, r_s6_b0_far);
            end else begin
                n_region    = REG_INT;
                n_sel.kind  = r_s6_dz ? KIND_C : KIND_QUAD;
                n_sel.qsel  = QSEL_INT;
                n_sel.a_num = r_s6_s;
                n_sel.a_den = r_s6_det;
            end
        end else if (r_s6_s < 0) begin
            n_region = REG_V2;
            n_sel    = (r_s6_num2 > 0) ? f_edge12(r_s6_num2, r_s6_denom, 1'b1)
                                       : f_edge02(r_s6_d, r_s6_b1_neg, r_s6_b1_far);
        end else if (r_s6_t < 0) begin
            n_region = REG_V1;
            n_sel    = (r_s6_num6 > 0) ? f_edge12(r_s6_num6, r_s6_denom, 1'b0)
                                       : f_edge01(r_s6_d, r_s6_b0_neg, r_s6_b0_far);
        end else begin
            n_region = REG_E12;
            if (r_s6_num2 > 0) begin
                n_sel = f_edge12(r_s6_num2, r_s6_denom, 1'b1);
            end else begin
                n_sel      = '0;
                n_sel.kind = KIND_V2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_diff[i] <= n_diff[i];
            r_s1_e0[i]   <= n_e0[i];
            r_s1_e1[i]   <= n_e1[i];
            r_s2_p[0][i] <= t_p34'(r_s1_e0[i]) * t_p34'(r_s1_e0[i]);
            r_s2_p[1][i] <= t_p34'(r_s1_e0[i]) * t_p34'(r_s1_e1[i]);
            r_s2_p[2][i] <= t_p34'(r_s1_e1[i]) * t_p34'(r_s1_e1[i]);
            r_s2_p[3][i] <= t_p34'(r_s1_diff[i]) * t_p34'(r_s1_e0[i]);
            r_s2_p[4][i] <= t_p34'(r_s1_diff[i]) * t_p34'(r_s1_e1[i]);
            r_s2_p[5][i] <= t_p34'(r_s1_diff[i]) * t_p34'(r_s1_diff[i]);
        end
        r_s3_d.a00 <= t_dot'(r_s2_p[0][0]) + t_dot'(r_s2_p[0][1]) + t_dot'(r_s2_p[0][2]);
        r_s3_d.a01 <= t_dot'(r_s2_p[1][0]) + t_dot'(r_s2_p[1][1]) + t_dot'(r_s2_p[1][2]);
        r_s3_d.a11 <= t_dot'(r_s2_p[2][0]) + t_dot'(r_s2_p[2][1]) + t_dot'(r_s2_p[2][2]);
        r_s3_d.b0  <= t_dot'(r_s2_p[3][0]) + t_dot'(r_s2_p[3][1]) + t_dot'(r_s2_p[3][2]);
        r_s3_d.b1  <= t_dot'(r_s2_p[4][0]) + t_dot'(r_s2_p[4][1]) + t_dot'(r_s2_p[4][2]);
        r_s3_d.c   <= t_dot'(r_s2_p[5][0]) + t_dot'(r_s2_p[5][1]) + t_dot'(r_s2_p[5][2]);

        // stage 4
        r_s4_d    <= r_s3_d;
        r_s4_m[0] <= t_wide'(r_s3_d.a00) * t_wide'(r_s3_d.a11);
        r_s4_m[1] <= t_wide'(r_s3_d.a01) * t_wide'(r_s3_d.a01);
        r_s4_m[2] <= t_wide'(r_s3_d.a01) * t_wide'(r_s3_d.b1);
        r_s4_m[3] <= t_wide'(r_s3_d.a11) * t_wide'(r_s3_d.b0);
        r_s4_m[4] <= t_wide'(r_s3_d.a01) * t_wide'(r_s3_d.b0);
        r_s4_m[5] <= t_wide'(r_s3_d.a00) * t_wide'(r_s3_d.b1);

        // stage 5
        r_s5_d   <= r_s4_d;
        r_s5_det <= (n_det_raw < 0) ? -n_det_raw : n_det_raw;
        r_s5_s   <= r_s4_m[2] - r_s4_m[3];
        r_s5_t   <= r_s4_m[4] - r_s4_m[5];

        // stage 6
        r_s6_d      <= r_s5_d;
        r_s6_det    <= r_s5_det;
        r_s6_s      <= r_s5_s;
        r_s6_t      <= r_s5_t;
        r_s6_dz     <= (r_s5_det == 0);
        r_s6_st_le  <= (r_s5_s + r_s5_t) <= r_s5_det;
        r_s6_b0_neg <= (r_s5_d.b0 < 0);
        r_s6_b1_neg <= (r_s5_d.b1 < 0);
        r_s6_b0_far <= (-t_wide'(r_s5_d.b0)) >= t_wide'(r_s5_d.a00);
        r_s6_b1_far <= (-t_wide'(r_s5_d.b1)) >= t_wide'(r_s5_d.a11);
        r_s6_num2   <= (t_wide'(r_s5_d.a11) + t_wide'(r_s5_d.b1))
                     - (t_wide'(r_s5_d.a01) + t_wide'(r_s5_d.b0));
        r_s6_num6   <= (t_wide'(r_s5_d.a00) + t_wide'(r_s5_d.b0))
                     - (t_wide'(r_s5_d.a01) + t_wide'(r_s5_d.b1));
        r_s6_denom  <= t_wide'(r_s5_d.a00) - t_wide'(r_s5_d.a01)
                     - t_wide'(r_s5_d.a01) + t_wide'(r_s5_d.a11);

        // stage 7
        r_s7_ctx.kind   <= n_sel.kind;
        r_s7_ctx.qsel   <= n_sel.qsel;
        r_s7_ctx.lin_b  <= n_sel.lin_b;
        r_s7_ctx.d      <= r_s6_d;
        r_s7_ctx.region <= n_region;
        r_s7_ctx.degen  <= r_s6_dz;
        r_s7_anum       <= n_sel.a_num;
        r_s7_aden       <= n_sel.a_den;
        r_s7_bnum       <= r_s6_t;
        r_s7_bden       <= r_s6_det;

        r_dly[0] <= r_s7_ctx;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    ptsd_div u_div_a (
        .i_clk (i_clk),
        .i_num (r_s7_anum),
        .i_den (r_s7_aden),
        .o_q   (w_qa)
    );

    ptsd_div u_div_b (
        .i_clk (i_clk),
        .i_num (r_s7_bnum),
        .i_den (r_s7_bden),
        .o_q   (w_qb)
    );

    always_comb begin
        case (r_dly[DIV_LAT-1].qsel)
            QSEL_S: begin
                n_s = w_qa;
                n_t = RATIO_ONE - w_qa;
            end
            QSEL_T: begin
                n_s = RATIO_ONE - w_qa;
                n_t = w_qa;
            end
            default: begin
                n_s = w_qa;
                n_t = w_qb;
            end
        endcase
        n_sum_u = (PRD_W+1)'(r_q1_p[0]) + (PRD_W+1)'(r_q1_p[1]);
        n_sum_v = (PRD_W+1)'(r_q1_p[2]) + (PRD_W+1)'(r_q1_p[3]);
        n_sum_q = (QP_W+1)'(r_q3_us) + (QP_W+1)'(r_q3_vt);
        case (r_q3_kind)
            KIND_V1:   n_dist = r_q3_v1;
            KIND_V2:   n_dist = r_q3_v2;
            KIND_LIN:  n_dist = r_q3_lin;
            KIND_QUAD: n_dist = t_acc'(n_sum_q >>> RATIO_FRAC) + r_q3_c;
            default:   n_dist = r_q3_c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // Q1: parameters and first products
        r_q1_ctx  <= r_dly[DIV_LAT-1];
        r_q1_s    <= n_s;
        r_q1_t    <= n_t;
        r_q1_p[0] <= t_prd'(r_dly[DIV_LAT-1].d.a00) * t_prd'($signed({1'b0, n_s}));
        r_q1_p[1] <= t_prd'(r_dly[DIV_LAT-1].d.a01) * t_prd'($signed({1'b0, n_t}));
        r_q1_p[2] <= t_prd'(r_dly[DIV_LAT-1].d.a01) * t_prd'($signed({1'b0, n_s}));
        r_q1_p[3] <= t_prd'(r_dly[DIV_LAT-1].d.a11) * t_prd'($signed({1'b0, n_t}));
        r_q1_p[4] <= t_prd'(r_dly[DIV_LAT-1].lin_b) * t_prd'($signed({1'b0, w_qa}));

        // Q2: inner sums
        r_q2_s      <= r_q1_s;
        r_q2_t      <= r_q1_t;
        r_q2_u      <= t_u'(n_sum_u >>> RATIO_FRAC) + t_u'(r_q1_ctx.d.b0) + t_u'(r_q1_ctx.d.b0);
        r_q2_v      <= t_u'(n_sum_v >>> RATIO_FRAC) + t_u'(r_q1_ctx.d.b1) + t_u'(r_q1_ctx.d.b1);
        r_q2_lin    <= t_acc'(r_q1_p[4] >>> RATIO_FRAC) + t_acc'(r_q1_ctx.d.c);
        r_q2_v1     <= t_acc'(r_q1_ctx.d.a00) + t_acc'(r_q1_ctx.d.b0)
                     + t_acc'(r_q1_ctx.d.b0) + t_acc'(r_q1_ctx.d.c);
        r_q2_v2     <= t_acc'(r_q1_ctx.d.a11) + t_acc'(r_q1_ctx.d.b1)
                     + t_acc'(r_q1_ctx.d.b1) + t_acc'(r_q1_ctx.d.c);
        r_q2_c      <= t_acc'(r_q1_ctx.d.c);
        r_q2_kind   <= r_q1_ctx.kind;
        r_q2_region <= r_q1_ctx.region;
        r_q2_degen  <= r_q1_ctx.degen;

        // Q3: outer products
        r_q3_us     <= t_qp'(r_q2_u) * t_qp'($signed({1'b0, r_q2_s}));
        r_q3_vt     <= t_qp'(r_q2_v) * t_qp'($signed({1'b0, r_q2_t}));
        r_q3_lin    <= r_q2_lin;
        r_q3_v1     <= r_q2_v1;
        r_q3_v2     <= r_q2_v2;
        r_q3_c      <= r_q2_c;
        r_q3_kind   <= r_q2_kind;
        r_q3_region <= r_q2_region;
        r_q3_degen  <= r_q2_degen;

        // Q4: distance select
        r_q4_dist   <= n_dist;
        r_q4_region <= r_q3_region;
        r_q4_degen  <= r_q3_degen;

        // output: clamp
        if (r_q4_dist < 0) begin
            r_out_dist <= '0;
        end else if (r_q4_dist > t_acc'(DIST_MAX)) begin
            r_out_dist <= DIST_MAX;
        end else begin
            r_out_dist <= r_q4_dist[DIST_W-1:0];
        end
        r_out_region <= r_q4_region;
        r_out_degen  <= r_q4_degen;
    end

    assign o_valid       = r_vld[PIPE_LAT-1];
    assign o_sq_distance = r_out_dist;
    assign o_region      = r_out_region;
    assign o_degenerate  = r_out_degen;

endmodule

`default_nettype wire

[hdl/ptsd_checker.sv]
// ============================================================================
// ptsd_checker
// Port-level checks for the point-to-triangle distance core.
// ============================================================================
`default_nettype none

module ptsd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                o_valid,
    input wire logic [ptsd_pkg::DIST_W-1:0]         o_sq_distance,
    input wire logic [ptsd_pkg::REG_W-1:0]          o_region,
    input wire logic                                o_degenerate
);
    import ptsd_pkg::*;

    // every result matches an item taken earlier (start while not busy)
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching item");

    a_degen_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_region == REG_INT))
        else $error("degenerate triangle outside interior region");

    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_region <= REG_V1))
        else $error("region code out of range");

    a_busy_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

bind point_triangle_sq_distance_core ptsd_checker u_ptsd_checker (.*);

`default_nettype wire

[tb/sv/tb_point_triangle_sq_distance_core.sv]
// ============================================================================
// tb_point_triangle_sq_distance_core
// Streams triangle/query items into the distance core and checks every result
// against a bit-exact predictor whose results queue in a small scoreboard class.
// ============================================================================
`timescale 1ns / 100ps

module tb_point_triangle_sq_distance_core;
    import ptsd_pkg::*;

    localparam int N_RANDOM  = 1350;
    localparam int LIMIT     = 400000;
    localparam int TAIL      = PIPE_LAT + 20;

    typedef logic signed [127:0] w_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef struct { coord_t c [12]; } pair_t;
    typedef struct { longint a00, a01, a11, b0, b1, c; } dots_t;
    typedef struct {
        logic [DIST_W-1:0] sq_dist;
        logic [REG_W-1:0]  region;
        logic              degen;
    } dist_res_t;

    function automatic w_t wx(longint x);
        w_t r;
        r = x;
        return r;
    endfunction

    function automatic longint frac_ratio(w_t num, w_t den);
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return longint'(RATIO_ONE);
        return longint'((num <<< RATIO_FRAC) / den);
    endfunction

    function automatic w_t quad_form(dots_t d, longint s, longint t);
        longint u, v;
        u = longint'(((wx(d.a00) * wx(s) + wx(d.a01) * wx(t)) >>> RATIO_FRAC) + wx(2 * d.b0));
        v = longint'(((wx(d.a01) * wx(s) + wx(d.a11) * wx(t)) >>> RATIO_FRAC) + wx(2 * d.b1));
        return ((wx(u) * wx(s) + wx(v) * wx(t)) >>> RATIO_FRAC) + wx(d.c);
    endfunction

    function automatic w_t lin_form(dots_t d, longint b, longint a);
        longint r;
        r = frac_ratio(wx(-b), wx(a));
        return ((wx(b) * wx(r)) >>> RATIO_FRAC) + wx(d.c);
    endfunction

    function automatic w_t at_v1(dots_t d);
        return wx(d.a00 + 2 * d.b0 + d.c);
    endfunction

    function automatic w_t at_v2(dots_t d);
        return wx(d.a11 + 2 * d.b1 + d.c);
    endfunction

    function automatic w_t on_e01(dots_t d);
        if (d.b0 >= 0) return wx(d.c);
        if (-d.b0 >= d.a00) return at_v1(d);
        return lin_form(d, d.b0, d.a00);
    endfunction

    function automatic w_t on_e02(dots_t d);
        if (d.b1 >= 0) return wx(d.c);
        if (-d.b1 >= d.a11) return at_v2(d);
        return lin_form(d, d.b1, d.a11);
    endfunction

    function automatic w_t on_e12(dots_t d, longint numer, bit s_side);
        longint denom, r, one;
        denom = d.a00 - 2 * d.a01 + d.a11;
        one = longint'(RATIO_ONE);
        if (numer >= denom) return s_side ? at_v1(d) : at_v2(d);
        r = frac_ratio(wx(numer), wx(denom));
        return s_side ? quad_form(d, r, one - r) : quad_form(d, one - r, r);
    endfunction

    function automatic dist_res_t predict_dist(pair_t p);
        longint df [3], e0 [3], e1 [3];
        longint tmp0, tmp1;
        dots_t d;
        w_t det, s, t, dv;
        dist_res_t res;
        for (int i = 0; i < 3; i++) begin
            df[i] = longint'(p.c[i]) - longint'(p.c[9+i]);
            e0[i] = longint'(p.c[3+i]) - longint'(p.c[i]);
            e1[i] = longint'(p.c[6+i]) - longint'(p.c[i]);
        end
        d.a00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
        d.a01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
        d.a11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
        d.b0  = df[0]*e0[0] + df[1]*e0[1] + df[2]*e0[2];
        d.b1  = df[0]*e1[0] + df[1]*e1[1] + df[2]*e1[2];
        d.c   = df[0]*df[0] + df[1]*df[1] + df[2]*df[2];
        det = wx(d.a00) * wx(d.a11) - wx(d.a01) * wx(d.a01);
        if (det < 0) det = -det;
        s = wx(d.a01) * wx(d.b1) - wx(d.a11) * wx(d.b0);
        t = wx(d.a01) * wx(d.b0) - wx(d.a00) * wx(d.b1);
        if (s + t <= det) begin
            if (s < 0) begin
                if (t < 0) begin
                    res.region = REG_V0;
                    dv = (d.b0 < 0) ? on_e01(d) : on_e02(d);
                end else begin
                    res.region = REG_E02;
                    dv = on_e02(d);
                end
            end else if (t < 0) begin
                res.region = REG_E01;
                dv = on_e01(d);
            end else begin
                res.region = REG_INT;
                if (det == 0) dv = wx(d.c);
                else dv = quad_form(d, frac_ratio(s, det), frac_ratio(t, det));
            end
        end else if (s < 0) begin
            tmp0 = d.a01 + d.b0;
            tmp1 = d.a11 + d.b1;
            res.region = REG_V2;
            dv = (tmp1 > tmp0) ? on_e12(d, tmp1 - tmp0, 1'b1) : on_e02(d);
        end else if (t < 0) begin
            tmp0 = d.a01 + d.b1;
            tmp1 = d.a00 + d.b0;
            res.region = REG_V1;
            dv = (tmp1 > tmp0) ? on_e12(d, tmp1 - tmp0, 1'b0) : on_e01(d);
        end else begin
            tmp0 = d.a11 + d.b1 - d.a01 - d.b0;
            res.region = REG_E12;
            dv = (tmp0 <= 0) ? at_v2(d) : on_e12(d, tmp0, 1'b1);
        end
        if (dv < 0) res.sq_dist = '0;
        else if (dv > wx(longint'(DIST_MAX))) res.sq_dist = DIST_MAX;
        else res.sq_dist = dv[DIST_W-1:0];
        res.degen = (det == 0);
        return res;
    endfunction

    class dist_scoreboard;
        dist_res_t pending [$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_item(pair_t p);
            pending.push_back(predict_dist(p));
        endfunction

        task check_result(logic [DIST_W-1:0] got_d, logic [REG_W-1:0] region, logic degen);
            dist_res_t exp_r;
            if (pending.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            exp_r = pending.pop_front();
            if (got_d !== exp_r.sq_dist)
                report($sformatf("sq_distance %0h, want %0h", got_d, exp_r.sq_dist));
            if (region !== exp_r.region)
                report($sformatf("region %0d, want %0d", region, exp_r.region));
            if (degen !== exp_r.degen)
                report($sformatf("degenerate %0b, want %0b", degen, exp_r.degen));
        endtask
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    coord_t pin [12];
    logic   busy, o_valid, o_degenerate;
    logic [DIST_W-1:0] o_sq_distance;
    logic [REG_W-1:0]  o_region;

    dist_scoreboard sb = new();
    int cycles = 0;

    initial for (int i = 0; i < 12; i++) pin[i] = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_triangle_sq_distance_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex0_x(pin[0]), .i_vertex0_y(pin[1]), .i_vertex0_z(pin[2]),
        .i_vertex1_x(pin[3]), .i_vertex1_y(pin[4]), .i_vertex1_z(pin[5]),
        .i_vertex2_x(pin[6]), .i_vertex2_y(pin[7]), .i_vertex2_z(pin[8]),
        .i_query_x(pin[9]), .i_query_y(pin[10]), .i_query_z(pin[11]),
        .o_valid(o_valid), .o_sq_distance(o_sq_distance),
        .o_region(o_region), .o_degenerate(o_degenerate)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_point_triangle_sq_distance_core: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid) sb.check_result(o_sq_distance, o_region, o_degenerate);

    int burst_left = 0;

    // one item: hold start until taken, then maybe open a gap
    task send_item(pair_t p);
        int gap;
        for (int i = 0; i < 12; i++) pin[i] <= p.c[i];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            for (int i = 0; i < 12; i++) pin[i] <= coord_t'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic pair_t tri_of(int x0, int y0, int z0, int x1, int y1, int z1,
                                     int x2, int y2, int z2, int qx, int qy, int qz);
        pair_t p;
        p.c = '{coord_t'(x0), coord_t'(y0), coord_t'(z0), coord_t'(x1), coord_t'(y1),
                coord_t'(z1), coord_t'(x2), coord_t'(y2), coord_t'(z2), coord_t'(qx),
                coord_t'(qy), coord_t'(qz)};
        return p;
    endfunction

    function automatic coord_t near_c(coord_t base, int span);
        return coord_t'(int'(base) + $urandom_range(0, 2 * span) - span);
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int mode, span;
        coord_t ext [4];
        int k;
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        mode = $urandom_range(0, 9);
        span = 1 << $urandom_range(2, 11);
        for (int i = 0; i < 12; i++) p.c[i] = coord_t'($urandom);
        case (mode)
            0, 1: ;
            2, 3, 4, 5, 6: begin
                for (int i = 0; i < 3; i++) begin
                    p.c[9+i] = coord_t'($urandom_range(0, 4095) - 2048);
                    p.c[i]   = near_c(p.c[9+i], span);
                    p.c[3+i] = near_c(p.c[9+i], span);
                    p.c[6+i] = near_c(p.c[9+i], span);
                end
            end
            7: begin
                k = $urandom_range(0, 3) - 1;
                for (int i = 0; i < 3; i++) begin
                    p.c[i]   = coord_t'($urandom_range(0, 2047) - 1024);
                    p.c[3+i] = near_c(p.c[i], 256);
                    p.c[6+i] = coord_t'(int'(p.c[i]) + k * (int'(p.c[3+i]) - int'(p.c[i])));
                    p.c[9+i] = near_c(p.c[i], 1024);
                end
            end
            8: for (int i = 0; i < 12; i++) p.c[i] = ext[$urandom_range(0, 3)];
            default: for (int i = 0; i < 3; i++) p.c[9+i] = ext[$urandom_range(0, 1)];
        endcase
        return p;
    endfunction

    initial begin
        pair_t dir [$];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // right triangle with legs of 256 in z=0, query in each of the seven regions
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,   64,  64, 100));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,  200, 200,   0));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,  -50, 400,  10));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0, -100, 100, -20));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0, -100,-100,   5));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,  100,-100,   0));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,  400, -50,  30));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0, 1000, -10,   0));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,  -10,1000,   0));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,    0,   0,   0));
        dir.push_back(tri_of(0,0,0, 256,0,0, 0,256,0,  256,   0,   0));
        // degenerate: coincident vertices and a collinear triangle
        dir.push_back(tri_of(5,5,5, 5,5,5, 5,5,5, 100, -3, 7));
        dir.push_back(tri_of(0,0,0, 100,100,100, 200,200,200, 50, -60, 70));
        // field extremes, saturation and far queries
        dir.push_back(tri_of(-32768,-32768,-32768, 32767,32767,32767,
                             -32768,32767,-32768, 32767,-32768,32767));
        dir.push_back(tri_of(-32768,-32768,-32768, -32768,-32768,-32768,
                             -32768,-32768,-32768, 32767,32767,32767));
        dir.push_back(tri_of(32767,32767,32767, 32767,32767,32767,
                             32767,32767,32767, 32767,32767,32767));
        dir.push_back(tri_of(-32768,0,0, 32767,0,0, 0,32767,0, 0,-32768,32767));
        dir.push_back(tri_of(-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1));
        dir.push_back(tri_of(0,0,0, 1,0,0, 0,1,0, 0,0,1));
        dir.push_back(tri_of(0,0,0, 32767,0,0, 0,32767,0, -32768,-32768,-32768));
        foreach (dir[i]) send_item(dir[i]);
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            send_item(rand_pair());
            if (n == N_RANDOM / 2) drain();
        end
        drain();
        repeat (TAIL) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_point_triangle_sq_distance_core: done, clean");
        else
            $display("tb_point_triangle_sq_distance_core: done, errors");
        $finish;
    end
endmodule

[filelist.f]
hdl/ptsd_pkg.sv
hdl/ptsd_div.sv
hdl/point_triangle_sq_distance_core.sv
hdl/ptsd_checker.sv
tb/sv/tb_point_triangle_sq_distance_core.sv
